FILE: src/lgs_pkg.sv
// shared types, codes and constants of the life grid generation step block
package lgs_pkg;

	// default grid capacity
	localparam int MAX_WIDTH_DEF  = 64;
	localparam int MAX_HEIGHT_DEF = 64;

	// field and register widths
	localparam int COORD_W   = 6;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
	localparam logic [CFG_W-1:0]     GRID_SIZE_RESET = 7'd64;

	// request action codes
	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_STEP  = 2'd2;

	// neighbor counts of the b3/s23 rule
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;
	localparam logic [3:0] BIRTH_COUNT   = 4'd3;

	typedef struct packed {
		logic [1:0]         action;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               alive;
	} lgs_req_t;

	typedef struct packed {
		logic cell_value;
		logic out_of_range;
	} lgs_rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CELL,
		ST_GFIRST,
		ST_GRUN,
		ST_DONE
	} lgs_state_t;

endpackage

FILE: src/lgs_row_mem.sv
// row-wide grid memory: one write port, one registered read port
module lgs_row_mem #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(MAX_HEIGHT)-1:0] waddr,
	input  logic [MAX_WIDTH-1:0]          wdata,
	input  logic                          re,
	input  logic [$clog2(MAX_HEIGHT)-1:0] raddr,
	output logic [MAX_WIDTH-1:0]          rdata
);
	logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/lgs_row_rule.sv
// next generation of one row from the old row above, the row itself and the row below
module lgs_row_rule #(
	parameter int MAX_WIDTH = 64
) (
	input  logic [MAX_WIDTH-1:0] prev_row,
	input  logic [MAX_WIDTH-1:0] cur_row,
	input  logic [MAX_WIDTH-1:0] next_row,
	input  logic [MAX_WIDTH-1:0] col_mask,
	output logic [MAX_WIDTH-1:0] new_row
);
	import lgs_pkg::*;

	logic [MAX_WIDTH+1:0] pp, cc, nn;

	// columns outside the grid in use and beyond the border count as dead
	assign pp = {1'b0, prev_row & col_mask, 1'b0};
	assign cc = {1'b0, cur_row & col_mask, 1'b0};
	assign nn = {1'b0, next_row & col_mask, 1'b0};

	// one counter and rule per column
	for (genvar j = 0; j < MAX_WIDTH; j++) begin : g_col
		logic [3:0] cnt;
		logic       live;

		assign cnt = 4'(pp[j]) + 4'(pp[j+1]) + 4'(pp[j+2])
			+ 4'(cc[j]) + 4'(cc[j+2])
			+ 4'(nn[j]) + 4'(nn[j+1]) + 4'(nn[j+2]);
		assign live = (cnt == BIRTH_COUNT) || (cur_row[j] && (cnt == SURVIVE_COUNT));
		// cells outside the grid in use keep their bit
		assign new_row[j] = col_mask[j] ? live : cur_row[j];
	end

endmodule

FILE: src/life_grid_generation_step.sv
// top level of the life grid generation step block: control, config and result register
//
// Usage: each request on req/req_valid/req_stall writes one cell, reads one cell
// or advances the grid by one b3/s23 generation. Every request gives exactly one
// result on rsp/rsp_valid/rsp_stall. The grid is kept as one memory word per row.
// A cell write or cell read has its row read at the accepting edge, then modified
// or selected, then loaded into the result register; a request with an
// out-of-range coordinate or an unused action goes straight to the result load.
// A generation step streams the rows through the memory read port and writes one
// new row per cycle.
// A new request is taken once the previous one has reached the result register,
// so a stalled result does not hold off the next request until a second result
// is ready. After reset the block clears the memory one row per cycle; req_stall
// stays high meanwhile. Config writes on
// cfg_we/cfg_index/cfg_data are taken at any time but must only be done while the
// block is idle. Reset sets both grid sizes to 64.
module life_grid_generation_step #(
	parameter int MAX_WIDTH  = lgs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = lgs_pkg::MAX_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lgs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lgs_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  lgs_pkg::lgs_req_t               req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output lgs_pkg::lgs_rsp_t               rsp
);
	import lgs_pkg::*;

	localparam int AW  = $clog2(MAX_HEIGHT);
	localparam int PW  = $clog2(MAX_HEIGHT + 1);
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int EWW = $clog2(MAX_WIDTH + 1);

	lgs_state_t state_q, state_d;

	logic [CFG_W-1:0] width_q, height_q;
	logic [EWW-1:0]   eff_w;
	logic [PW-1:0]    eff_h;

	logic [1:0]         act_q;
	logic [COORD_W-1:0] col_q, row_q;
	logic               alive_q;
	lgs_rsp_t           res_q;
	lgs_rsp_t           rsp_q;
	logic               rsp_valid_q;

	logic [PW-1:0]        rd_ptr_q, wr_ptr_q;
	logic [MAX_WIDTH-1:0] prev_q, cur_q;

	logic                 mem_we, mem_re;
	logic [AW-1:0]        mem_waddr, mem_raddr;
	logic [MAX_WIDTH-1:0] mem_wdata, mem_rdata;

	logic                 acc, req_oor, has_next, rd_more, load_rsp;
	logic [CW-1:0]        col_idx;
	logic [MAX_WIDTH-1:0] col_mask, next_row, new_row, row_mod;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= GRID_SIZE_RESET;
			height_q <= GRID_SIZE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_GRID_WIDTH) begin
				width_q <= cfg_data;
			end else if (cfg_index == CFG_GRID_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	// clamp grid sizes to 1..max
	always_comb begin
		if (width_q == '0) begin
			eff_w = EWW'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			eff_w = EWW'(MAX_WIDTH);
		end else begin
			eff_w = EWW'(width_q);
		end
		if (height_q == '0) begin
			eff_h = PW'(1);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			eff_h = PW'(MAX_HEIGHT);
		end else begin
			eff_h = PW'(height_q);
		end
	end

	// columns in use
	for (genvar j = 0; j < MAX_WIDTH; j++) begin : g_mask
		assign col_mask[j] = (j < int'(eff_w));
	end

	assign acc       = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign req_oor   = (int'(req.col) >= int'(eff_w)) || (int'(req.row) >= int'(eff_h));
	assign col_idx   = CW'(col_q);
	assign has_next  = ({1'b0, wr_ptr_q} + (PW+1)'(1)) < {1'b0, eff_h};
	assign rd_more   = (rd_ptr_q < eff_h);
	assign next_row  = has_next ? mem_rdata : '0;
	assign load_rsp  = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);

	// cell write merges the new bit into the row
	always_comb begin
		row_mod          = mem_rdata;
		row_mod[col_idx] = alive_q;
	end

	lgs_row_mem #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	lgs_row_rule #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_rule (
		.prev_row(prev_q),
		.cur_row (cur_q),
		.next_row(next_row),
		.col_mask(col_mask),
		.new_row (new_row)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory control
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = wr_ptr_q[AW-1:0];
				if (wr_ptr_q == PW'(MAX_HEIGHT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (acc) begin
					priority if ((req.action == ACT_WRITE || req.action == ACT_READ) && !req_oor) begin
						mem_re    = 1'b1;
						mem_raddr = AW'(req.row);
						state_d   = ST_CELL;
					end else if (req.action == ACT_STEP) begin
						mem_re  = 1'b1;
						state_d = ST_GFIRST;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_CELL: begin
				if (act_q == ACT_WRITE) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(row_q);
					mem_wdata = row_mod;
				end
				state_d = ST_DONE;
			end
			ST_GFIRST: begin
				mem_re    = rd_more;
				mem_raddr = rd_ptr_q[AW-1:0];
				state_d   = ST_GRUN;
			end
			ST_GRUN: begin
				mem_we    = 1'b1;
				mem_waddr = wr_ptr_q[AW-1:0];
				mem_wdata = new_row;
				mem_re    = rd_more;
				mem_raddr = rd_ptr_q[AW-1:0];
				if (!has_next) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load_rsp) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// row pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
		end else begin
			if (state_q == ST_CLEAR) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (state_q == ST_IDLE && acc) begin
				rd_ptr_q <= PW'(1);
				wr_ptr_q <= '0;
			end
			if ((state_q == ST_GFIRST || state_q == ST_GRUN) && rd_more) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (state_q == ST_GRUN) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
		end
	end

	// request fields, row window and pending result
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && acc) begin
			act_q   <= req.action;
			col_q   <= req.col;
			row_q   <= req.row;
			alive_q <= req.alive;
			res_q.cell_value   <= 1'b0;
			res_q.out_of_range <= (req.action == ACT_WRITE || req.action == ACT_READ) && req_oor;
		end
		if (state_q == ST_CELL && act_q == ACT_READ) begin
			res_q.cell_value <= mem_rdata[col_idx];
		end
		if (state_q == ST_GFIRST) begin
			prev_q <= '0;
			cur_q  <= mem_rdata;
		end
		if (state_q == ST_GRUN) begin
			prev_q <= cur_q;
			cur_q  <= next_row;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// no read and write of the same row in one cycle
	a_no_rw_same_row: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("grid row read and written in the same cycle");

	// generation never writes past the last row in use
	a_gen_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GRUN) |-> (wr_ptr_q < eff_h))
		else $error("generation write row beyond grid height");

	// a new result only comes from the done state
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside the done state");

	// an out-of-range access never returns a cell value
	a_oor_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.cell_value && rsp.out_of_range))
		else $error("out-of-range result carries a cell value");

endmodule
